FILE: rtl/core/lfp_pkg.sv
// Shared types and constants for the lidar frame parser.
// Used by the parser top level, its output buffer and the port checker.
`default_nettype none

package lfp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'h59;
  localparam logic [3:0] POS_HDR0 = 4'd0;
  localparam logic [3:0] POS_HDR1 = 4'd1;
  localparam logic [3:0] POS_DATA0 = 4'd2;
  localparam logic [3:0] POS_CSUM = 4'd8;
  localparam int unsigned PAYLOAD_BYTES = 6;
  localparam int unsigned OUT_CNT_W = 32;

  localparam logic REG_MIN_DIST = 1'b0;
  localparam logic REG_MAX_DIST = 1'b1;

  localparam logic [15:0] MIN_DIST_RST = 16'd1;
  localparam logic [15:0] MAX_DIST_RST = 16'd1200;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_VALID      = 2'd1,
    ST_CSUM_ERR   = 2'd2,
    ST_RANGE_ERR  = 2'd3
  } lfp_status_e;

  typedef struct packed {
    lfp_status_e            status;
    logic [15:0]            distance;
    logic [15:0]            strength;
    logic signed [15:0]     temperature;
    logic                   have_valid;
    logic [OUT_CNT_W-1:0]   good_frames;
    logic [OUT_CNT_W-1:0]   bad_frames;
    logic [OUT_CNT_W-1:0]   byte_total;
  } lfp_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/lfp_skid.sv
// Two-entry output buffer for parser results: result register plus skid register.
// Depends on lfp_pkg for the result record type.
`default_nettype none

module lfp_skid (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lfp_pkg::lfp_result_t in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output lfp_pkg::lfp_result_t      out_data_o
);
  import lfp_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  lfp_result_t out_data_q, out_data_d;
  lfp_result_t skid_data_q, skid_data_d;
  logic        push;
  logic        pop;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign push        = in_valid_i && !skid_valid_q;
  assign pop         = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (push) begin
      if (out_valid_q && !out_ready_i) begin
        skid_data_d  = in_data_i;
        skid_valid_d = 1'b1;
      end else begin
        out_data_d  = in_data_i;
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/lidar_frame_parser.sv
// Byte-serial parser for 9-byte lidar frames: header hunt, running checksum, decode.
// Depends on lfp_pkg and instantiates lfp_skid for the result side.
// A result is registered in the buffer's result slot, or the skid slot while output stalls.
// Throughput: one byte per cycle while the buffer is not full; a running checksum register
// means each byte is final work. The two-entry result buffer keeps taking bytes
// while one result waits downstream. Reset clears the parser position, held measurement,
// counters and sets the distance limits to 1 and 1200; the frame byte buffer is not reset.
`default_nettype none

module lidar_frame_parser #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      distance_o,
  output logic [15:0]      strength_o,
  output logic signed [15:0] temp_raw_o,
  output logic             have_valid_o,
  output logic [31:0]      good_frames_o,
  output logic [31:0]      bad_frames_o,
  output logic [31:0]      byte_total_o
);
  import lfp_pkg::*;

  logic [15:0]             min_dist_q, max_dist_q;
  logic [3:0]              pos_q, pos_d;
  logic [7:0]              sum_q, sum_d;
  logic [7:0]              frame_q [PAYLOAD_BYTES];
  logic [2:0]              wr_idx;
  logic                    frame_we;
  logic [15:0]             held_dist_q, held_dist_d;
  logic [15:0]             held_str_q, held_str_d;
  logic [15:0]             held_temp_q, held_temp_d;
  logic                    valid_flag_q, valid_flag_d;
  logic [COUNTER_BITS-1:0] good_q, good_d;
  logic [COUNTER_BITS-1:0] bad_q, bad_d;
  logic [COUNTER_BITS-1:0] rcv_q, rcv_d;
  logic [15:0]             dec_dist, dec_str, dec_temp;
  lfp_status_e             status;
  logic                    accept;
  lfp_result_t             result;
  lfp_result_t             res_data;

  assign accept   = rx_valid_i && rx_ready_o;
  assign wr_idx   = 3'(pos_q - POS_DATA0);
  assign dec_dist = {frame_q[1], frame_q[0]};
  assign dec_str  = {frame_q[3], frame_q[2]};
  assign dec_temp = {frame_q[5], frame_q[4]};

  always_comb begin
    pos_d        = pos_q;
    sum_d        = sum_q;
    frame_we     = 1'b0;
    status       = ST_INCOMPLETE;
    held_dist_d  = held_dist_q;
    held_str_d   = held_str_q;
    held_temp_d  = held_temp_q;
    valid_flag_d = valid_flag_q;
    good_d       = good_q;
    bad_d        = bad_q;
    rcv_d        = rcv_q + COUNTER_BITS'(1);
    case (pos_q)
      POS_HDR0: begin
        if (rx_byte_i == HDR_BYTE) begin
          pos_d = POS_HDR1;
          sum_d = HDR_BYTE;
        end
      end
      POS_HDR1: begin
        if (rx_byte_i == HDR_BYTE) begin
          pos_d = POS_DATA0;
          sum_d = sum_q + rx_byte_i;
        end else begin
          pos_d = POS_HDR0;
        end
      end
      POS_CSUM: begin
        pos_d = POS_HDR0;
        if (sum_q != rx_byte_i) begin
          status = ST_CSUM_ERR;
          bad_d  = bad_q + COUNTER_BITS'(1);
        end else if (dec_dist < min_dist_q || dec_dist > max_dist_q) begin
          status = ST_RANGE_ERR;
          bad_d  = bad_q + COUNTER_BITS'(1);
        end else begin
          status       = ST_VALID;
          held_dist_d  = dec_dist;
          held_str_d   = dec_str;
          held_temp_d  = dec_temp;
          valid_flag_d = 1'b1;
          good_d       = good_q + COUNTER_BITS'(1);
        end
      end
      default: begin
        frame_we = 1'b1;
        sum_d    = sum_q + rx_byte_i;
        pos_d    = pos_q + 4'd1;
      end
    endcase
  end

  always_comb begin
    result.status      = status;
    result.distance    = held_dist_d;
    result.strength    = held_str_d;
    result.temperature = held_temp_d;
    result.have_valid  = valid_flag_d;
    result.good_frames = OUT_CNT_W'(good_d);
    result.bad_frames  = OUT_CNT_W'(bad_d);
    result.byte_total  = OUT_CNT_W'(rcv_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q   <= MIN_DIST_RST;
      max_dist_q   <= MAX_DIST_RST;
      pos_q        <= POS_HDR0;
      sum_q        <= '0;
      held_dist_q  <= '0;
      held_str_q   <= '0;
      held_temp_q  <= '0;
      valid_flag_q <= 1'b0;
      good_q       <= '0;
      bad_q        <= '0;
      rcv_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MIN_DIST) begin
          min_dist_q <= cfg_wdata_i;
        end else begin
          max_dist_q <= cfg_wdata_i;
        end
      end
      if (accept) begin
        pos_q        <= pos_d;
        sum_q        <= sum_d;
        held_dist_q  <= held_dist_d;
        held_str_q   <= held_str_d;
        held_temp_q  <= held_temp_d;
        valid_flag_q <= valid_flag_d;
        good_q       <= good_d;
        bad_q        <= bad_d;
        rcv_q        <= rcv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && frame_we) begin
      frame_q[wr_idx] <= rx_byte_i;
    end
  end

  lfp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_valid_i),
    .in_ready_o  (rx_ready_o),
    .in_data_i   (result),
    .out_valid_o (res_valid_o),
    .out_ready_i (res_ready_i),
    .out_data_o  (res_data)
  );

  assign status_o      = res_data.status;
  assign distance_o    = res_data.distance;
  assign strength_o    = res_data.strength;
  assign temp_raw_o    = res_data.temperature;
  assign have_valid_o  = res_data.have_valid;
  assign good_frames_o = res_data.good_frames;
  assign bad_frames_o  = res_data.bad_frames;
  assign byte_total_o  = res_data.byte_total;

endmodule

`default_nettype wire

FILE: rtl/core/lfp_checker.sv
// Port-level checker for the lidar frame parser, bound to the top level.
// Depends on lfp_pkg for the status codes.
`default_nettype none

module lfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rx_ready_o,
  input wire logic        res_valid_o,
  input wire logic        res_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] distance_o,
  input wire logic        have_valid_o,
  input wire logic [31:0] good_frames_o
);
  import lfp_pkg::*;

  // When the input side is held off, both result slots are full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> res_valid_o)
    else $error("input stalled with no result pending");

  // A request that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result request dropped before it was taken");

  // A good frame always leaves a held measurement behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == ST_VALID |-> have_valid_o)
    else $error("good frame without the valid flag");

  // Before any good frame, the held measurement and good count are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !have_valid_o |-> good_frames_o == '0 && distance_o == '0)
    else $error("measurement or good count set without a good frame");

endmodule

bind lidar_frame_parser lfp_checker u_lfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_ready_o    (rx_ready_o),
  .res_valid_o   (res_valid_o),
  .res_ready_i   (res_ready_i),
  .status_o      (status_o),
  .distance_o    (distance_o),
  .have_valid_o  (have_valid_o),
  .good_frames_o (good_frames_o)
);

`default_nettype wire
